// ===== hdl/bgcd_pkg.sv =====
package bgcd_pkg;

  localparam int unsigned OpW       = 64;
  localparam int unsigned ShiftW    = 6;
  localparam int unsigned InTdataW  = 128;
  localparam int unsigned OutTdataW = 72;
  localparam int unsigned PadW      = OutTdataW - OpW - 1;

  localparam logic [OpW-1:0] One = {{(OpW-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic [OpW-1:0] min_val;
    logic [OpW-1:0] half_diff;
  } alu_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

// ===== hdl/binary_gcd_coprime_test.sv =====
// Binary GCD unit with coprimality flag.
// A request on the slave stream carries two unsigned 64-bit operands; the
// master stream returns one result per request: their greatest common
// divisor and a flag that is set when the divisor equals one. A zero operand
// yields the other operand; two zero operands yield zero, not coprime.
// The operands are loaded into the sequencer registers, then a single shared
// compare and subtract unit runs one step per cycle: shift out a common factor
// of two, shift one operand, or replace the larger by half the difference.
// Each step removes at least one bit from the pair, so small values need
// fewer steps from acceptance to the result register.
// The block takes one request at a time; s_axis_tready_o is high only while
// the sequencer is idle. The result sits in an output register; while the
// receiver stalls it holds there, and a finished computation waits in the
// sequencer until that register is free. Reset clears the sequencer and the
// output valid flag; no request is lost or repeated across a stall.
module binary_gcd_coprime_test import bgcd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [63:0] first_value, [127:64] second_value
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [63:0] divisor, [64] is_coprime, [71:65] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  seq_stat_t      stat;
  logic [OpW-1:0] divisor;
  logic           is_coprime;
  logic           out_free;
  logic           m_valid_q, m_valid_d;
  logic [OpW:0]   m_data_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  bgcd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s_axis_tvalid_i && stat.idle),
    .first_i      (s_axis_tdata_i[OpW-1:0]),
    .second_i     (s_axis_tdata_i[2*OpW-1:OpW]),
    .out_ready_i  (out_free),
    .stat_o       (stat),
    .divisor_o    (divisor),
    .is_coprime_o (is_coprime)
  );

  assign s_axis_tready_o = stat.idle;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, m_data_q};

  always_comb begin
    m_valid_d = m_valid_q;
    if (stat.done) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      m_data_q <= {is_coprime, divisor};
    end
  end

endmodule

// ===== hdl/bgcd_alu.sv =====
module bgcd_alu import bgcd_pkg::*; (
  input  logic [OpW-1:0] a_i,
  input  logic [OpW-1:0] b_i,
  output alu_res_t       res_o
);

  logic           a_gt_b;
  logic [OpW-1:0] big;
  logic [OpW-1:0] diff;

  // Both operands are odd here, so the difference is even and loses its zero bit.
  assign a_gt_b          = a_i > b_i;
  assign big             = a_gt_b ? a_i : b_i;
  assign res_o.min_val   = a_gt_b ? b_i : a_i;
  assign diff            = big - res_o.min_val;
  assign res_o.half_diff = {1'b0, diff[OpW-1:1]};

endmodule

// ===== hdl/bgcd_seq.sv =====
module bgcd_seq import bgcd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [OpW-1:0] first_i,
  input  logic [OpW-1:0] second_i,
  input  logic           out_ready_i,
  output seq_stat_t      stat_o,
  output logic [OpW-1:0] divisor_o,
  output logic           is_coprime_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [OpW-1:0]    a_q, a_d;
  logic [OpW-1:0]    b_q, b_d;
  logic [ShiftW-1:0] k_q, k_d;
  logic              done;
  alu_res_t          alu_res;

  bgcd_alu u_alu (
    .a_i   (a_q),
    .b_i   (b_q),
    .res_o (alu_res)
  );

  assign divisor_o    = a_q << k_q;
  assign is_coprime_o = (divisor_o == One);
  assign stat_o.idle  = (state_q == ST_IDLE);
  assign stat_o.done  = done;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    done    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          // A zero first operand makes the second one the result directly.
          a_d     = (first_i == '0) ? second_i : first_i;
          b_d     = (first_i == '0) ? '0 : second_i;
          k_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (b_q == '0) begin
          if (out_ready_i) begin
            done    = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = {1'b0, a_q[OpW-1:1]};
          b_d = {1'b0, b_q[OpW-1:1]};
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = {1'b0, a_q[OpW-1:1]};
        end else if (!b_q[0]) begin
          b_d = {1'b0, b_q[OpW-1:1]};
        end else begin
          a_d = alu_res.min_val;
          b_d = alu_res.half_diff;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

`ifndef ASSERT_OFF
  a_nonzero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (a_q != '0 || b_q == '0))
    else $error("first operand register went to zero while the second is nonzero");

  strip_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && b_q != '0 && !a_q[0] && !b_q[0])
      |=> (k_q == $past(k_q) + 1'b1))
    else $error("common power of two not counted");

  odd_keep_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && b_q != '0 && a_q[0] && b_q[0]) |=> a_q[0])
    else $error("smaller operand lost its odd bit after subtraction");

  done_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after a result");
`endif

endmodule
